>>> hdl/assert_macros.svh
// assertion macros used by the keyed row cache top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define KRC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KRC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/krc_pkg.sv
// package with sizes, opcodes and shared types of the keyed row cache
`default_nettype none

package krc_pkg;

	localparam int ENTRIES  = 8;
	localparam int MAX_ROWS = 8;
	localparam int ROW_BITS = 64;
	localparam int KEY_BITS = 64;

	localparam int STAMP_W = 32;
	localparam int ENT_W   = $clog2(ENTRIES);
	localparam int RIDX_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CNT_W   = $clog2(MAX_ROWS + 1);
	localparam int USED_W  = $clog2(ENTRIES + 1);
	localparam int ADDR_W  = $clog2(ENTRIES * MAX_ROWS);

	typedef enum logic [1:0] {
		OP_STAGE = 2'd0,
		OP_PUT   = 2'd1,
		OP_GET   = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// result of one compare step against a single entry
	typedef struct packed {
		logic match;
		logic empty;
		logic older;
	} cmp_t;

	function automatic logic [ADDR_W-1:0] row_addr(input logic [ENT_W-1:0] slot,
		input logic [RIDX_W-1:0] row);
		return ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_ROWS) + ADDR_W'(row));
	endfunction

endpackage

`default_nettype wire

>>> hdl/krc_req_if.sv
// request channel: stage, put and get transactions
`default_nettype none

interface krc_req_if;
	logic              valid;
	logic              ready;
	logic [1:0]        opcode;
	logic [63:0]       key;
	logic [2:0]        row_index;
	logic [63:0]       row_value;
	logic signed [7:0] put_rows;

	modport source(output valid, opcode, key, row_index, row_value, put_rows,
		input ready);
	modport sink(input valid, opcode, key, row_index, row_value, put_rows,
		output ready);
endinterface

`default_nettype wire

>>> hdl/krc_rsp_if.sv
// response channel: rows returned by a get
`default_nettype none

interface krc_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [2:0]  out_row_index;
	logic [63:0] out_row_value;
	logic [3:0]  stored_rows;
	logic [3:0]  entries_used;
	logic        last;

	modport source(output valid, hit, out_row_index, out_row_value, stored_rows,
		entries_used, last, input ready);
	modport sink(input valid, hit, out_row_index, out_row_value, stored_rows,
		entries_used, last, output ready);
endinterface

`default_nettype wire

>>> hdl/krc_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none

module krc_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hdl/krc_cmp.sv
// shared compare unit: key match, free slot and stamp age against one entry
`default_nettype none

module krc_cmp import krc_pkg::*; (
	input  wire logic [KEY_BITS-1:0] key,
	input  wire logic                ent_vld,
	input  wire logic [KEY_BITS-1:0] ent_key,
	input  wire logic [STAMP_W-1:0]  ent_stamp,
	input  wire logic [STAMP_W-1:0]  best_stamp,
	output      cmp_t                res
);

	always_comb begin
		res.match = ent_vld && (ent_key == key);
		res.empty = !ent_vld;
		res.older = ent_stamp < best_stamp;
	end

endmodule

`default_nettype wire

>>> hdl/keyed_row_cache_oldest_write_evict.sv
// keyed row cache top level: entry table, staging buffer and sequencer
//
//   channel | interface     | carries
//   req     | krc_req_if    | opcode, key, row_index, row_value, put_rows
//   rsp     | krc_rsp_if    | hit, out_row_index, out_row_value, stored_rows,
//           |               | entries_used, last
//
// stage and no-op transactions complete in idle; put and get first walk
// the entry table one entry per cycle through the shared compare unit
// and then pick the slot. a put then writes one row per cycle into the
// row ram. a get hit streams one row per cycle, unless rsp.ready stalls
// it, out of the ram read port; a miss gives a single result. reset clears
// the entry valid bits, counters and staging valid bits at once; the row
// ram is never read before its entry is written. the output register
// lets the next request in while the final result waits on rsp.ready.
`default_nettype none
`include "assert_macros.svh"

module keyed_row_cache_oldest_write_evict import krc_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	krc_req_if.sink  req,
	krc_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_COPY,
		S_READ,
		S_MISS
	} state_t;

	state_t               state_q;
	op_t                  op_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [CNT_W-1:0]     n_q;
	logic [ENT_W-1:0]     scan_q;
	logic                 found_q;
	logic [ENT_W-1:0]     hit_slot_q;
	logic                 empty_found_q;
	logic [ENT_W-1:0]     empty_slot_q;
	logic [ENT_W-1:0]     best_slot_q;
	logic [STAMP_W-1:0]   best_stamp_q;
	logic [ENT_W-1:0]     slot_q;
	logic                 new_q;
	logic [CNT_W-1:0]     row_q;

	logic [ENTRIES-1:0]   ent_vld_q;
	logic [KEY_BITS-1:0]  ent_key_q [ENTRIES];
	logic [STAMP_W-1:0]   ent_stamp_q [ENTRIES];
	logic [CNT_W-1:0]     ent_cnt_q [ENTRIES];
	logic [ROW_BITS-1:0]  stg_q [MAX_ROWS];
	logic [MAX_ROWS-1:0]  stg_vld_q;
	logic [STAMP_W-1:0]   clock_q;
	logic [USED_W-1:0]    used_q;

	logic                 vld_s1;
	logic [RIDX_W-1:0]    idx_s1;
	logic                 last_s1;

	logic                 out_vld_q;
	logic                 hit_q;
	logic [2:0]           out_idx_q;
	logic [63:0]          out_val_q;
	logic [3:0]           stored_q;
	logic [3:0]           used_out_q;
	logic                 last_q;

	logic [KEY_BITS-1:0]  req_key;
	logic [CNT_W-1:0]     req_n;
	logic                 req_acc;
	logic                 stage_ok;
	logic [RIDX_W-1:0]    stage_idx;
	cmp_t                 cmp;
	logic                 scan_last;
	logic [RIDX_W-1:0]    row_idx;
	logic                 copy_we;
	logic                 copy_last;
	logic [ROW_BITS-1:0]  copy_data;
	logic                 more_rows;
	logic                 out_free;
	logic                 load_s1;
	logic                 issue;
	logic                 miss_load;
	logic                 out_load;
	logic [ROW_BITS-1:0]  rd_data;

	assign req.ready = (state_q == S_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign req_key   = KEY_BITS'(req.key);
	assign stage_ok  = int'(req.row_index) < MAX_ROWS;
	assign stage_idx = RIDX_W'(req.row_index);

	// clamp the signed request count to 0..MAX_ROWS
	always_comb begin
		if (req.put_rows < 0) begin
			req_n = '0;
		end else if (int'(req.put_rows) > MAX_ROWS) begin
			req_n = CNT_W'(MAX_ROWS);
		end else begin
			req_n = CNT_W'(unsigned'(req.put_rows));
		end
	end

	krc_cmp u_cmp (
		.key        (key_q),
		.ent_vld    (ent_vld_q[scan_q]),
		.ent_key    (ent_key_q[scan_q]),
		.ent_stamp  (ent_stamp_q[scan_q]),
		.best_stamp (best_stamp_q),
		.res        (cmp)
	);

	assign scan_last = (scan_q == ENT_W'(ENTRIES - 1));
	assign row_idx   = row_q[RIDX_W-1:0];
	assign copy_we   = (state_q == S_COPY);
	assign copy_last = copy_we && (row_q == CNT_W'(MAX_ROWS - 1));
	assign copy_data = ((row_q < n_q) && stg_vld_q[row_idx]) ? stg_q[row_idx] : '0;

	// read side: ram stage s1 feeding the output register
	assign more_rows = row_q < CNT_W'(MAX_ROWS);
	assign out_free  = !out_vld_q || rsp.ready;
	assign load_s1   = (state_q == S_READ) && vld_s1 && out_free;
	assign issue     = (state_q == S_READ) && more_rows && (!vld_s1 || load_s1);
	assign miss_load = (state_q == S_MISS) && out_free;
	assign out_load  = load_s1 || miss_load;

	krc_ram #(
		.DEPTH (ENTRIES * MAX_ROWS),
		.WIDTH (ROW_BITS)
	) u_rows (
		.clk   (clk),
		.we    (copy_we),
		.waddr (row_addr(slot_q, row_idx)),
		.wdata (copy_data),
		.re    (issue),
		.raddr (row_addr(slot_q, row_idx)),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			found_q       <= 1'b0;
			empty_found_q <= 1'b0;
			new_q         <= 1'b0;
			scan_q        <= '0;
			row_q         <= '0;
			ent_vld_q     <= '0;
			stg_vld_q     <= '0;
			clock_q       <= '0;
			used_q        <= '0;
			vld_s1        <= 1'b0;
			out_vld_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end

			if (issue) begin
				vld_s1 <= 1'b1;
			end else if (load_s1) begin
				vld_s1 <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						found_q       <= 1'b0;
						empty_found_q <= 1'b0;
						scan_q        <= '0;
						unique case (op_t'(req.opcode))
							OP_STAGE: begin
								if (stage_ok) begin
									stg_vld_q[stage_idx] <= 1'b1;
								end
							end
							OP_PUT: begin
								if (req_key != '0) begin
									state_q <= S_SCAN;
								end
							end
							OP_GET: begin
								state_q <= (req_key != '0) ? S_SCAN : S_MISS;
							end
							OP_NOP: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (cmp.match && !found_q) begin
						found_q <= 1'b1;
					end
					if (cmp.empty && !empty_found_q) begin
						empty_found_q <= 1'b1;
					end
					scan_q <= scan_q + 1'b1;
					if (scan_last) begin
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					row_q <= '0;
					new_q <= !found_q && empty_found_q;
					if (op_q == OP_PUT) begin
						state_q <= S_COPY;
					end else begin
						state_q <= found_q ? S_READ : S_MISS;
					end
				end
				S_COPY: begin
					row_q <= row_q + 1'b1;
					if (copy_last) begin
						ent_vld_q[slot_q] <= 1'b1;
						used_q            <= used_q + USED_W'(new_q);
						clock_q           <= clock_q + 1'b1;
						stg_vld_q         <= '0;
						state_q           <= S_IDLE;
					end
				end
				S_READ: begin
					if (issue) begin
						row_q <= row_q + 1'b1;
					end
					if (load_s1 && last_s1) begin
						state_q <= S_IDLE;
					end
				end
				S_MISS: begin
					if (miss_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers, qualified by the control state above
	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q  <= op_t'(req.opcode);
			key_q <= req_key;
			n_q   <= req_n;
			if ((op_t'(req.opcode) == OP_STAGE) && stage_ok) begin
				stg_q[stage_idx] <= ROW_BITS'(req.row_value);
			end
		end
		if (state_q == S_SCAN) begin
			if (cmp.match && !found_q) begin
				hit_slot_q <= scan_q;
			end
			if (cmp.empty && !empty_found_q) begin
				empty_slot_q <= scan_q;
			end
			// first entry seeds the oldest search, strict compare keeps lowest index
			if (scan_q == '0 || cmp.older) begin
				best_slot_q  <= scan_q;
				best_stamp_q <= ent_stamp_q[scan_q];
			end
		end
		if (state_q == S_PICK) begin
			if (found_q) begin
				slot_q <= hit_slot_q;
			end else if (empty_found_q && op_q == OP_PUT) begin
				slot_q <= empty_slot_q;
			end else begin
				slot_q <= best_slot_q;
			end
		end
		if (copy_last) begin
			ent_key_q[slot_q]   <= key_q;
			ent_cnt_q[slot_q]   <= n_q;
			ent_stamp_q[slot_q] <= clock_q;
		end
		if (issue) begin
			idx_s1  <= row_idx;
			last_s1 <= (row_q == CNT_W'(MAX_ROWS - 1));
		end
		if (out_load) begin
			hit_q      <= load_s1;
			out_idx_q  <= load_s1 ? 3'(idx_s1) : 3'd0;
			out_val_q  <= load_s1 ? 64'(rd_data) : 64'd0;
			stored_q   <= load_s1 ? 4'(ent_cnt_q[slot_q]) : 4'd0;
			used_out_q <= 4'(used_q);
			last_q     <= load_s1 ? last_s1 : 1'b1;
		end
	end

	assign rsp.valid         = out_vld_q;
	assign rsp.hit           = hit_q;
	assign rsp.out_row_index = out_idx_q;
	assign rsp.out_row_value = out_val_q;
	assign rsp.stored_rows   = stored_q;
	assign rsp.entries_used  = used_out_q;
	assign rsp.last          = last_q;

	`KRC_ASSERT(a_used_matches_valid, $countones(ent_vld_q) == int'(used_q),
		"occupied entry count disagrees with valid bits")
	`KRC_ASSERT(a_load_needs_room, !out_load || out_free,
		"output register overwritten while a result is pending")
	`KRC_ASSERT(a_s1_only_in_read, !vld_s1 || state_q == S_READ,
		"read stage holds data outside a get")
	`KRC_ASSERT_NEXT(a_put_clears_staging, copy_last, stg_vld_q == '0,
		"staging buffer not cleared after a put")
	`KRC_ASSERT_NEXT(a_put_stamps_entry, copy_last,
		ent_vld_q[$past(slot_q)] && ent_stamp_q[$past(slot_q)] == $past(clock_q),
		"put left its entry unstamped")

endmodule

`default_nettype wire
